@@ rtl/mts_pkg.sv @@
// Shared types and constants for the midtones transfer stretch block.
package mts_pkg;

    localparam int unsigned Q_ONE_I = 65536;
    localparam logic [16:0] Q_ONE   = 17'd65536;
    localparam logic [16:0] Q_HALF  = 17'd32768;
    localparam int unsigned PIXEL_BITS_DEF = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned N_QBITS = 18;
    localparam int unsigned X_QBITS = 17;
    localparam int unsigned Y_QBITS = 17;

    localparam logic [1:0] CFG_WHITE      = 2'd0;
    localparam logic [1:0] CFG_SHADOWS    = 2'd1;
    localparam logic [1:0] CFG_HIGHLIGHTS = 2'd2;
    localparam logic [1:0] CFG_MIDTONES   = 2'd3;

    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_DIV  = 2'd2
    } t_cls;

    // Clip points and midtones, already saturated to 1.0.
    typedef struct packed {
        logic [16:0] lo;
        logic [16:0] hi;
        logic [16:0] m;
    } t_cfg;

    typedef struct packed {
        t_cls        cls;
        logic [15:0] nd;
    } t_item;

endpackage

@@ rtl/mts_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module mts_div import mts_pkg::*; #(
    parameter int unsigned NUM_W  = 33,
    parameter int unsigned DEN_W  = 17,
    parameter int unsigned Q_W    = 17,
    parameter int unsigned SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic [DEN_W-1:0]  r_rem  [Q_W];
    logic [Q_W-1:0]    r_nlo  [Q_W];
    logic [Q_W-1:0]    r_quo  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];
    logic [Q_W-1:0]    r_vld;

    logic [DEN_W-1:0]  n_rem  [Q_W];
    logic [Q_W-1:0]    n_nlo  [Q_W];
    logic [Q_W-1:0]    n_quo  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [Q_W-1:0]   nlo_in;
        logic [Q_W-1:0]   quo_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   t;
        logic             ge;
        if (k == 0) begin : g_first
            // caller guarantees the quotient fits in Q_W bits
            assign rem_in = DEN_W'(i_num >> Q_W);
            assign nlo_in = i_num[Q_W-1:0];
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign nlo_in = r_nlo[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
        end
        assign t  = {rem_in, nlo_in[Q_W-1]};
        assign ge = (t >= {1'b0, den_in});
        assign n_rem[k] = ge ? DEN_W'(t - {1'b0, den_in}) : DEN_W'(t);
        assign n_nlo[k] = nlo_in << 1;
        assign n_quo[k] = {quo_in[Q_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Q_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_nlo[k] <= n_nlo[k];
                r_quo[k] <= n_quo[k];
            end
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k < Q_W; k++) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

@@ rtl/mts_front.sv @@
// Front end: normalize the pixel by the white level and classify it.
module mts_front import mts_pkg::*; #(
    parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic [PIXEL_BITS-1:0] i_white,
    input  t_cfg                  i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_item                 o_item
);

    localparam int unsigned NUM_W = PIXEL_BITS + 17;
    localparam int unsigned DEN_W = PIXEL_BITS + 1;

    logic              en;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic              ovf;
    logic              div_vld;
    logic [N_QBITS-1:0] quo;
    logic              ovf_q;
    logic [N_QBITS-1:0] n;

    assign en      = !div_vld || i_ready;
    assign o_ready = en;
    assign o_valid = div_vld;

    always_comb begin
        num = {i_pixel, 17'd0} + NUM_W'(i_white);
        den = (i_white == '0) ? DEN_W'(1) : {i_white, 1'b0};
        // quotient of 2^18 or more only ever compares above both clip points
        ovf = ((num >> N_QBITS) >= NUM_W'(den));
    end

    mts_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (N_QBITS),
        .SIDE_W(1)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(i_valid),
        .i_num  (ovf ? '0 : num),
        .i_den  (den),
        .i_side (ovf),
        .o_valid(div_vld),
        .o_quo  (quo),
        .o_side (ovf_q)
    );

    always_comb begin
        n = ovf_q ? '1 : quo;
        o_item.nd = 16'(n - N_QBITS'(i_cfg.lo));
        if (n <= N_QBITS'(i_cfg.lo)) begin
            o_item.cls = CLS_ZERO;
        end else if (n >= N_QBITS'(i_cfg.hi)) begin
            o_item.cls = CLS_ONE;
        end else begin
            o_item.cls = CLS_DIV;
        end
    end

endmodule

@@ rtl/mts_queue.sv @@
// Small queue between front and back ends.
module mts_queue import mts_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    localparam int unsigned PW = $clog2(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != PW'(0) + (PW+1)'(DEPTH)) ;
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule

@@ rtl/mts_back.sv @@
// Back end: scale between clip points, midtones transfer, rescale to white.
module mts_back import mts_pkg::*; #(
    parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_item                 i_item,
    input  logic [PIXEL_BITS-1:0] i_white,
    input  t_cfg                  i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIXEL_BITS-1:0] o_pixel
);

    localparam int unsigned PW = PIXEL_BITS + 17;

    logic en;

    // scale stage
    logic [16:0] d;
    logic [32:0] num2;
    logic [17:0] den2;
    logic        v2;
    logic [16:0] q2;
    logic [1:0]  cls2;

    // multiply stage
    logic [16:0] x;
    logic [16:0] c;
    logic        r_va;
    logic [33:0] r_a;
    logic [33:0] r_b;
    logic        r_mlt;
    logic        r_sp_a;
    logic [16:0] r_ysp_a;

    // denominator stage
    logic [33:0] dd;
    logic        r_vb;
    logic [51:0] r_num3;
    logic [34:0] r_den3;
    logic        r_sp_b;
    logic [16:0] r_ysp_b;

    logic        v3;
    logic [16:0] q3;
    logic [17:0] side3;

    logic          r_vc;
    logic [PW-1:0] r_prod;

    logic [PW:0]   sum;
    logic [PIXEL_BITS+1:0] rnd;
    logic          r_vd;

    assign en      = !r_vd || i_ready;
    assign o_ready = en;
    assign o_valid = r_vd;

    always_comb begin
        d = i_cfg.hi - i_cfg.lo;
        if (i_item.cls == CLS_DIV) begin
            num2 = {i_item.nd, 17'd0} + 33'(d);
            den2 = {d, 1'b0};
        end else begin
            num2 = '0;
            den2 = 18'd1;
        end
    end

    mts_div #(
        .NUM_W (33),
        .DEN_W (18),
        .Q_W   (X_QBITS),
        .SIDE_W(2)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(i_valid),
        .i_num  (num2),
        .i_den  (den2),
        .i_side (i_item.cls),
        .o_valid(v2),
        .o_quo  (q2),
        .o_side (cls2)
    );

    always_comb begin
        case (t_cls'(cls2))
            CLS_ZERO: x = '0;
            CLS_ONE:  x = Q_ONE;
            default:  x = q2;
        endcase
        c = ({i_cfg.m, 1'b0} <= {1'b0, Q_ONE}) ? 17'(Q_ONE - {i_cfg.m[15:0], 1'b0})
                                               : 17'({i_cfg.m, 1'b0} - {1'b0, Q_ONE});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a    <= 34'(Q_ONE - i_cfg.m) * 34'(x);
            r_b    <= 34'(c) * 34'(x);
            r_mlt  <= ({i_cfg.m, 1'b0} <= {1'b0, Q_ONE});
            r_sp_a <= (i_cfg.m == '0) || (i_cfg.m == Q_HALF) || (i_cfg.m >= Q_ONE);
            if (i_cfg.m == '0) begin
                r_ysp_a <= '0;
            end else if (i_cfg.m == Q_HALF) begin
                r_ysp_a <= x;
            end else begin
                r_ysp_a <= Q_ONE;
            end
        end
    end

    always_comb begin
        dd = r_mlt ? ({1'b0, i_cfg.m, 16'd0} + r_b) : ({1'b0, i_cfg.m, 16'd0} - r_b);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // special midtones values bypass the divider
            r_num3  <= r_sp_a ? '0 : ({1'b0, r_a, 17'd0} + 52'(dd));
            r_den3  <= r_sp_a ? 35'd1 : {dd, 1'b0};
            r_sp_b  <= r_sp_a;
            r_ysp_b <= r_ysp_a;
        end
    end

    mts_div #(
        .NUM_W (52),
        .DEN_W (35),
        .Q_W   (Y_QBITS),
        .SIDE_W(18)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_vb),
        .i_num  (r_num3),
        .i_den  (r_den3),
        .i_side ({r_sp_b, r_ysp_b}),
        .o_valid(v3),
        .o_quo  (q3),
        .o_side (side3)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= PW'(side3[17] ? side3[16:0] : q3) * PW'(i_white);
        end
    end

    always_comb begin
        sum = (PW+1)'(r_prod) + (PW+1)'(Q_HALF);
        rnd = (PIXEL_BITS+2)'(sum >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_pixel <= (rnd > (PIXEL_BITS+2)'(i_white)) ? i_white : rnd[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (en) begin
            r_va <= v2;
            r_vb <= r_va;
            r_vc <= v3;
            r_vd <= r_vc;
        end
    end

endmodule

@@ rtl/midtones_transfer_stretch.sv @@
// Top level of the midtones transfer stretch block.
//
//  channel   signals                              direction
//  input     i_valid / o_ready, i_pixel_in        in
//  output    o_valid / i_ready, o_pixel_out       out
//  config    i_cfg_wr_en, i_cfg_index, i_cfg_data in, write only
//
// One pixel per cycle sustained while the output is not stalled; each beat
// passes 18 front divider stages, the queue and 38 back stages (two pipelined
// dividers, three multiplies, rounding).
// Synchronous active-low reset clears valid state and loads register defaults.
// Output stalls hold the back end; the queue lets the front keep accepting until it is full.
module midtones_transfer_stretch import mts_pkg::*; #(
    parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_pixel_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pixel_out,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam logic [15:0] TOP = 16'((32'd1 << PIXEL_BITS) - 32'd1);

    logic [15:0] r_white;
    logic [16:0] r_shadows;
    logic [16:0] r_highlights;
    logic [16:0] r_midtones;

    logic [PIXEL_BITS-1:0] w_sat;
    logic [PIXEL_BITS-1:0] p_sat;
    logic [PIXEL_BITS-1:0] pix_out;
    t_cfg  cfg;
    logic  f_valid;
    logic  f_ready;
    t_item f_item;
    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white      <= 16'hFFFF;
            r_shadows    <= '0;
            r_highlights <= Q_ONE;
            r_midtones   <= Q_HALF;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_WHITE:      r_white      <= i_cfg_data[15:0];
                CFG_SHADOWS:    r_shadows    <= i_cfg_data;
                CFG_HIGHLIGHTS: r_highlights <= i_cfg_data;
                CFG_MIDTONES:   r_midtones   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb begin
        w_sat  = (r_white > TOP) ? TOP[PIXEL_BITS-1:0] : r_white[PIXEL_BITS-1:0];
        // clamp samples wider than the pixel width
        p_sat  = (i_pixel_in > TOP) ? TOP[PIXEL_BITS-1:0] : i_pixel_in[PIXEL_BITS-1:0];
        cfg.lo = (r_shadows    > Q_ONE) ? Q_ONE : r_shadows;
        cfg.hi = (r_highlights > Q_ONE) ? Q_ONE : r_highlights;
        cfg.m  = (r_midtones   > Q_ONE) ? Q_ONE : r_midtones;
    end

    assign o_pixel_out = 16'(pix_out);

    mts_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_pixel(p_sat),
        .i_white(w_sat),
        .i_cfg  (cfg),
        .o_valid(f_valid),
        .i_ready(f_ready),
        .o_item (f_item)
    );

    mts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(f_valid),
        .o_ready(f_ready),
        .i_item (f_item),
        .o_valid(q_valid),
        .i_ready(q_ready),
        .o_item (q_item)
    );

    mts_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_ready(q_ready),
        .i_item (q_item),
        .i_white(w_sat),
        .i_cfg  (cfg),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_pixel(pix_out)
    );

    a_sat_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (pix_out <= w_sat))
        else $error("output above white level");

    a_mid_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cfg.m == Q_ONE) |-> (pix_out == w_sat))
        else $error("midtones at one must give white");

    a_mid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cfg.m == '0) |-> (pix_out == '0))
        else $error("midtones at zero must give black");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pixel_out)))
        else $error("stalled output beat changed");

endmodule
